>>> rtl/core/rbiw_pkg.sv
// shared types, constants and helper functions of the boot image run writer
// no dependencies; imported by every module of the block
package rbiw_pkg;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	// register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_PIXEL_MODE    = 2'd2;

	localparam logic [13:0] SCREEN_WIDTH_RST  = 14'd1024;
	localparam logic [13:0] SCREEN_HEIGHT_RST = 14'd768;

	// pixel modes
	localparam logic [1:0] MODE_16BPP = 2'd0;
	localparam logic [1:0] MODE_24BPP = 2'd1;
	localparam logic [1:0] MODE_32BPP = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// parse phases
	localparam logic [1:0] PH_WIDTH  = 2'd0;
	localparam logic [1:0] PH_HEIGHT = 2'd1;
	localparam logic [1:0] PH_COUNT  = 2'd2;
	localparam logic [1:0] PH_GRAY   = 2'd3;

	// x/6 as (x * 43691) >> 18, exact for 14-bit x
	localparam logic [15:0] SIXTH_MUL   = 16'd43691;
	localparam int          SIXTH_SHIFT = 18;

	localparam logic [13:0] SIXTH_HEIGHT_RST =
		14'((int'(SCREEN_HEIGHT_RST) * int'(SIXTH_MUL)) >> SIXTH_SHIFT);

	// reciprocal table: floor(2^16 / w), used for the row wrap quotient
	localparam int RECIP_ONE   = 65536;
	localparam int RECIP_FRAC  = 16;

	typedef logic [16:0] recip_tab_t [256];

	// long division by shift and subtract, evaluated once at elaboration
	function automatic recip_tab_t build_recip_tab();
		recip_tab_t  t;
		logic [16:0] q;
		logic [8:0]  r;
		t[0] = '0;
		for (int i = 1; i < 256; i++) begin
			q = '0;
			r = '0;
			for (int k = RECIP_FRAC; k >= 0; k--) begin
				r = {r[7:0], RECIP_ONE[k]};
				if (r >= 9'(i)) begin
					r = 9'(r - 9'(i));
					q[k] = 1'b1;
				end
			end
			t[i] = q;
		end
		return t;
	endfunction

	localparam recip_tab_t RECIP_TAB = build_recip_tab();

	typedef struct packed {
		logic [13:0] screen_width;
		logic [13:0] screen_height;
		logic [1:0]  pixel_mode;
		logic [13:0] sixth_height;
	} cfg_t;

	typedef struct packed {
		logic [12:0] row;
		logic [13:0] start_column;
		logic [7:0]  run_length;
		logic [31:0] pixel_word;
		logic [27:0] byte_offset;
		logic        image_number;
		logic        image_done;
	} res_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [1:0] image;
	} stat_t;

	// gray byte expanded to the frame buffer pixel format
	function automatic logic [31:0] expand_gray(input logic [7:0] g, input logic [1:0] mode);
		logic [31:0] w;
		case (mode)
			MODE_16BPP: w = {16'd0, g[7:3], g[7:2], g[7:3]};
			MODE_24BPP: w = {8'd0, g, g, g};
			default:    w = {g, g, g, g};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/rle_boot_image_run_writer_core.sv
// top level of the run-length boot image run writer: input register,
// parser, result register and config port; depends on rbiw_pkg,
// rbiw_cfg_regs and rbiw_parser
//
// channel   direction  handshake               payload
// in        input      in_valid / in_stall     image_byte
// out       output     out_valid / out_stall   row, start_column, run_length,
//                                              pixel_word, byte_offset,
//                                              image_number, image_done
// cfg       input      psel/penable/pwrite     paddr, pwdata -> prdata
//
// one byte per cycle while in_stall is low; a gray byte's run reaches the outputs
// through the input register, then the result register
// the count byte of a pair starts the row-wrap quotient, the gray byte ends it
// arst_n clears the parser to "expect width byte" of the upper image
// out_stall holds the result register; in_stall rises only when the input
// register is full and cannot move into a held result register
module rle_boot_image_run_writer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// byte stream
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        image_byte,
	// run results
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [12:0]                       row,
	output logic [13:0]                       start_column,
	output logic [7:0]                        run_length,
	output logic [31:0]                       pixel_word,
	output logic [27:0]                       byte_offset,
	output logic                              image_number,
	output logic                              image_done,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rbiw_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [rbiw_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [rbiw_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import rbiw_pkg::*;

	cfg_t        cfg;
	res_t        res;
	res_t        res_q;
	stat_t       stat;
	logic        emit;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        res_valid_q;
	logic        advance;

	rbiw_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the held byte moves on when the result register is empty or being read
	assign advance  = valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= image_byte;
		end
	end

	rbiw_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (advance),
		.image_byte (byte_s1),
		.cfg        (cfg),
		.emit       (emit),
		.res        (res),
		.stat       (stat)
	);

	// result register: loads a new run, drops the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = res_valid_q;
	assign row          = res_q.row;
	assign start_column = res_q.start_column;
	assign run_length   = res_q.run_length;
	assign pixel_word   = res_q.pixel_word;
	assign byte_offset  = res_q.byte_offset;
	assign image_number = res_q.image_number;
	assign image_done   = res_q.image_done;

`ifndef NO_ASSERTIONS
	// a stall upstream only while a byte is actually held
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall without a held byte");

	// a run only comes out of a gray byte of an image still in progress
	a_emit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (stat.phase == PH_GRAY) && !stat.image[1])
		else $error("run emitted outside gray phase");

	// a new run never overwrites a result still held by the sink
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !(res_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	// the image counter only steps when a header or a final run ends an image
	a_image_step: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.image != $past(stat.image)) |-> ($past(stat.phase) == PH_HEIGHT
			|| $past(stat.phase) == PH_GRAY))
		else $error("image counter moved outside an image end");
`endif

endmodule

>>> rtl/core/rbiw_cfg_regs.sv
// configuration registers behind the apb-style port, plus the registered
// screen_height/6 term; depends on rbiw_pkg
module rbiw_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rbiw_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [rbiw_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [rbiw_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	output rbiw_pkg::cfg_t                      cfg
);
	import rbiw_pkg::*;

	logic [13:0] screen_width_q;
	logic [13:0] screen_height_q;
	logic [1:0]  pixel_mode_q;
	logic [13:0] sixth_q;
	logic [29:0] sixth_prod;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// height/6 of the value being written, loaded together with the register
	assign sixth_prod = 30'(pwdata[13:0]) * 30'(SIXTH_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
			pixel_mode_q    <= MODE_32BPP;
			sixth_q         <= SIXTH_HEIGHT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[13:0];
				REG_SCREEN_HEIGHT: begin
					screen_height_q <= pwdata[13:0];
					sixth_q         <= 14'(sixth_prod >> SIXTH_SHIFT);
				end
				REG_PIXEL_MODE:    pixel_mode_q    <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SCREEN_WIDTH:  prdata = 32'(screen_width_q);
			REG_SCREEN_HEIGHT: prdata = 32'(screen_height_q);
			REG_PIXEL_MODE:    prdata = 32'(pixel_mode_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg = '{screen_width: screen_width_q, screen_height: screen_height_q,
		pixel_mode: pixel_mode_q, sixth_height: sixth_q};

endmodule

>>> rtl/core/rbiw_parser.sv
// file parser: header bytes, run pairs, cursor update and run result
// depends on rbiw_pkg
module rbiw_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [7:0]         image_byte,
	input  rbiw_pkg::cfg_t     cfg,
	output logic               emit,
	output rbiw_pkg::res_t     res,
	output rbiw_pkg::stat_t    stat
);
	import rbiw_pkg::*;

	logic [1:0]  phase_q;
	logic [1:0]  image_q;
	logic [7:0]  width_q;
	logic [16:0] recip_q;
	logic [13:0] left_q;
	logic [7:0]  rel_q;
	logic [13:0] row_q;
	logic [13:0] end_row_q;
	logic [7:0]  count_q;
	logic [8:0]  sum_q;
	logic [8:0]  qest_q;

	logic        active;
	logic [13:0] left_next;
	logic [13:0] start_row;
	logic [8:0]  sum_next;
	logic [25:0] recip_prod;
	logic [27:0] row_prod;
	logic [16:0] qw;
	logic [8:0]  rem0;
	logic        wrap;
	logic [8:0]  rem;
	logic [9:0]  quot;
	logic [13:0] new_row;
	logic        done;
	logic [13:0] col;
	logic [27:0] base;
	logic [27:0] offset;

	assign active = go && (cfg.pixel_mode != MODE_NONE) && !image_q[1];

	// header math
	assign left_next = (cfg.screen_width >= 14'(image_byte))
		? 14'((cfg.screen_width - 14'(image_byte)) >> 1) : '0;
	assign start_row = (image_q[0] == 1'b0) ? cfg.sixth_height
		: 14'(cfg.screen_height - cfg.sixth_height);

	// count byte: position within the row plus run, quotient estimate
	assign sum_next   = 9'(rel_q) + 9'(image_byte);
	assign recip_prod = 26'(sum_next) * 26'(recip_q);

	// gray byte: finish the quotient with one correction step
	assign qw      = 17'(qest_q) * 17'(width_q);
	assign rem0    = sum_q - qw[8:0];
	assign wrap    = rem0 >= 9'(width_q);
	assign rem     = wrap ? 9'(rem0 - 9'(width_q)) : rem0;
	assign quot    = 10'(qest_q) + 10'(wrap);
	assign new_row = row_q + 14'(quot);
	assign done    = new_row >= end_row_q;

	// row base with the screen width in force for this run
	assign row_prod = 28'(row_q) * 28'(cfg.screen_width);
	assign col      = left_q + 14'(rel_q);
	assign base     = row_prod + 28'(col);

	always_comb begin
		case (cfg.pixel_mode)
			MODE_16BPP: offset = base << 1;
			MODE_24BPP: offset = base + (base << 1);
			default:    offset = base << 2;
		endcase
	end

	assign emit = active && (phase_q == PH_GRAY);

	assign res = '{row: row_q[12:0], start_column: col, run_length: count_q,
		pixel_word: expand_gray(image_byte, cfg.pixel_mode), byte_offset: offset,
		image_number: image_q[0], image_done: done};

	assign stat = '{phase: phase_q, image: image_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WIDTH;
			image_q   <= '0;
			width_q   <= '0;
			left_q    <= '0;
			rel_q     <= '0;
			row_q     <= '0;
			end_row_q <= '0;
			count_q   <= '0;
		end else if (active) begin
			case (phase_q)
				PH_WIDTH: begin
					width_q <= image_byte;
					left_q  <= left_next;
					rel_q   <= '0;
					phase_q <= PH_HEIGHT;
				end
				PH_HEIGHT: begin
					row_q     <= start_row;
					end_row_q <= start_row + 14'(image_byte);
					if (width_q == '0 || image_byte == '0) begin
						image_q <= image_q + 2'd1;
						phase_q <= PH_WIDTH;
					end else begin
						phase_q <= PH_COUNT;
					end
				end
				PH_COUNT: begin
					count_q <= image_byte;
					phase_q <= PH_GRAY;
				end
				PH_GRAY: begin
					rel_q <= rem[7:0];
					row_q <= new_row;
					if (done) begin
						image_q <= image_q + 2'd1;
						phase_q <= PH_WIDTH;
					end else begin
						phase_q <= PH_COUNT;
					end
				end
				default: phase_q <= PH_WIDTH;
			endcase
		end
	end

	// datapath registers with no reset
	always_ff @(posedge clk) begin
		if (active && phase_q == PH_WIDTH) begin
			recip_q <= RECIP_TAB[image_byte];
		end
		if (active && phase_q == PH_COUNT) begin
			sum_q  <= sum_next;
			qest_q <= recip_prod[RECIP_FRAC+8:RECIP_FRAC];
		end
	end

endmodule
